// ===== rtl/core/qwst_pkg.sv =====
// ----------------------------------------------------------------------------
// qwst_pkg
// Shared types, constants and the step decode for the wheel speed tracker.
// ----------------------------------------------------------------------------
package qwst_pkg;

    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);
    localparam int LAG_W      = 4;
    localparam int CMP_W      = (FILL_W > LAG_W) ? FILL_W : LAG_W;
    localparam int IDX_W      = RING_AW + 2;
    localparam int MS_PER_S   = 1000;
    localparam int PROD_W     = 42;
    localparam int CNT_W      = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [30:0] SPEED_MAX = 31'h7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LAG    = 2'd2;

    localparam logic [15:0] MIN_INTERVAL_RST = 16'd50;
    localparam logic [15:0] MAX_INTERVAL_RST = 16'd500;
    localparam logic [LAG_W-1:0] SPEED_LAG_RST = 4'd4;

    localparam logic [1:0] PIN_MASK_A = 2'h1;
    localparam logic [1:0] PIN_MASK_B = 2'h2;

    typedef enum logic [1:0] {
        FUNC_EDGE    = 2'd0,
        FUNC_TIMEOUT = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_UNUSED  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2,
        DIR_BAD  = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_READ,
        S_LOAD,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [31:0]       divisor;
    } t_div_req;

    function automatic t_dir step_decode(input logic [1:0] old_pins,
                                         input logic [1:0] new_pins);
        t_dir d;
        unique case ({old_pins, new_pins})
            4'b0000, 4'b0101, 4'b1010, 4'b1111: d = DIR_NONE;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_FWD;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_BWD;
            default:                            d = DIR_BAD;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/qwst_if.sv =====
// ----------------------------------------------------------------------------
// qwst_if
// Valid/ready channels for edge items and speed reports.
// ----------------------------------------------------------------------------
interface qwst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        sensor_sel;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, func, sensor_sel, pin_level, now_ms, input ready);
    modport sink   (input valid, func, sensor_sel, pin_level, now_ms, output ready);
endinterface

interface qwst_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_time;
    logic [30:0] speed;
    logic [1:0]  direction;
    logic [31:0] count_at_dir_change;
    logic [31:0] pulse_total;

    modport source (output valid, sample_time, speed, direction, count_at_dir_change,
                    pulse_total, input ready);
    modport sink   (input valid, sample_time, speed, direction, count_at_dir_change,
                    pulse_total, output ready);
endinterface

// ===== rtl/core/qwst_div.sv =====
// ----------------------------------------------------------------------------
// qwst_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qwst_div
    import qwst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    logic [31:0]       r_rem;
    logic [PROD_W-1:0] r_quo;
    logic [31:0]       r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        fits;

    assign rem_sh  = {r_rem, r_quo[PROD_W-1]};
    assign fits    = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            // shift in next dividend bit, subtract when it fits
            r_rem <= fits ? rem_sub[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/quadrature_wheel_speed_tracker_core.sv =====
// ----------------------------------------------------------------------------
// quadrature_wheel_speed_tracker_core
// Quadrature step decode, pulse counting, history ring and speed reports.
// ----------------------------------------------------------------------------
// Sequence: an item without report passes through accept and update. A report
//   with a speed computation runs update, ring read, 1000x product, then the
//   serial divider, then the output load.
// Throughput: one transaction at a time; the divider loop and output back-pressure set the rate.
// Reset: synchronous active-low i_rst_n clears counts, direction, ring
//   pointers and report times and loads configuration defaults. The ring
//   memory is not cleared: only entries within the fill count are read.
module quadrature_wheel_speed_tracker_core
    import qwst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    qwst_in_if.sink              i_in,
    qwst_out_if.source           o_out
);

    // configuration
    logic [15:0]      r_min_int;
    logic [15:0]      r_max_int;
    logic [LAG_W-1:0] r_lag;

    // captured transaction
    t_func       r_func;
    logic        r_sel;
    logic        r_level;
    logic [31:0] r_now;

    // tracker state
    logic [1:0]         r_pin;
    logic [31:0]        r_pulses;
    logic [31:0]        r_dcc;
    t_dir               r_dir;
    logic [RING_AW-1:0] r_head;
    logic [FILL_W-1:0]  r_fill;
    logic [31:0]        r_last_rep;
    logic [31:0]        r_last_sample;

    // speed path
    logic [RING_AW-1:0] r_rd_addr;
    logic [63:0]        r_rd_data;
    logic [PROD_W-1:0]  r_prod;
    logic [31:0]        r_dm;
    logic [30:0]        r_speed;

    // output register
    logic        r_out_valid;
    logic [31:0] r_o_time;
    logic [30:0] r_o_speed;
    logic [1:0]  r_o_dir;
    logic [31:0] r_o_dcc;
    logic [31:0] r_o_pulses;

    t_state r_state, n_state;

    // history ring: {time, pulse count}
    logic [63:0] r_mem [RING_DEPTH];

    logic               mem_we;
    logic [RING_AW-1:0] mem_waddr;

    // update step, combinational from the captured transaction
    logic [1:0]         n_pin;
    t_dir               step_dir;
    logic               dir_chg;
    logic [31:0]        n_pulses;
    logic [31:0]        n_dcc;
    t_dir               n_dir;
    logic [RING_AW-1:0] head_base;
    logic [FILL_W-1:0]  fill_base;
    logic [RING_AW-1:0] n_head;
    logic [FILL_W-1:0]  n_fill;
    logic               report;
    logic               need_speed;
    logic [31:0]        elapsed;
    logic [CMP_W-1:0]   lag_eff;
    logic [IDX_W-1:0]   idx_tmp;
    logic [RING_AW-1:0] n_rd_addr;

    logic [31:0] dp;
    logic [31:0] dm;

    t_div_req          div_req;
    logic              div_done;
    logic [PROD_W-1:0] div_quo;

    assign i_in.ready = (r_state == S_IDLE);
    assign elapsed    = r_now - r_last_rep;

    always_comb begin
        n_pin     = r_pin;
        step_dir  = DIR_NONE;
        dir_chg   = 1'b0;
        n_pulses  = r_pulses;
        n_dcc     = r_dcc;
        n_dir     = r_dir;
        head_base = r_head;
        fill_base = r_fill;
        mem_we    = 1'b0;
        report    = 1'b0;
        unique case (r_func)
            FUNC_EDGE: begin
                n_pin    = r_level ? (r_pin | (r_sel ? PIN_MASK_B : PIN_MASK_A))
                                   : (r_pin & ~(r_sel ? PIN_MASK_B : PIN_MASK_A));
                step_dir = step_decode(r_pin, n_pin);
                n_pulses = r_pulses + 32'd1;
                dir_chg  = ((step_dir == DIR_FWD) || (step_dir == DIR_BWD))
                           && (r_dir != step_dir);
                if (dir_chg) begin
                    // new direction: restart the history
                    head_base = '0;
                    fill_base = '0;
                    n_dcc     = n_pulses;
                    n_dir     = step_dir;
                end
                mem_we = 1'b1;
                report = elapsed >= {16'd0, r_min_int};
            end
            FUNC_TIMEOUT: begin
                report = elapsed >= {16'd0, r_max_int};
                // repeat the newest entry at the new time
                mem_we = report && (r_fill != '0);
            end
            FUNC_CLEAR: begin
                n_pulses  = '0;
                n_dcc     = '0;
                n_dir     = DIR_NONE;
                head_base = '0;
                fill_base = '0;
            end
            default: ;
        endcase
        mem_waddr = head_base;
        if (mem_we) begin
            n_head = (head_base == RING_AW'(RING_DEPTH - 1)) ? '0 : head_base + 1'b1;
            n_fill = (fill_base == FILL_W'(RING_DEPTH)) ? fill_base : fill_base + 1'b1;
        end else begin
            n_head = head_base;
            n_fill = fill_base;
        end
        // clamp lag to the fill and locate the older entry
        if (CMP_W'(r_lag) > CMP_W'(n_fill - 1'b1)) begin
            lag_eff = CMP_W'(n_fill - 1'b1);
        end else begin
            lag_eff = CMP_W'(r_lag);
        end
        need_speed = (n_fill >= FILL_W'(2)) && (lag_eff != '0);
        idx_tmp = IDX_W'(n_head) + IDX_W'(RING_DEPTH - 1) - IDX_W'(lag_eff);
        if (idx_tmp >= IDX_W'(RING_DEPTH)) begin
            idx_tmp = idx_tmp - IDX_W'(RING_DEPTH);
        end
        n_rd_addr = idx_tmp[RING_AW-1:0];
    end

    assign dp = r_pulses - r_rd_data[31:0];
    assign dm = r_now - r_rd_data[63:32];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_dm;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!report) begin
                    n_state = S_IDLE;
                end else if (need_speed) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                n_state = ((dp == '0) || (dm == '0)) ? S_DONE : S_DIV_START;
            end
            S_DIV_START: begin
                div_req.start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_int <= MIN_INTERVAL_RST;
            r_max_int <= MAX_INTERVAL_RST;
            r_lag     <= SPEED_LAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_INTERVAL: r_min_int <= i_cfg_data;
                CFG_MAX_INTERVAL: r_max_int <= i_cfg_data;
                CFG_SPEED_LAG:    r_lag     <= i_cfg_data[LAG_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func  <= t_func'(i_in.func);
            r_sel   <= i_in.sensor_sel;
            r_level <= i_in.pin_level;
            r_now   <= i_in.now_ms;
        end
    end

    // tracker state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin         <= '0;
            r_pulses      <= '0;
            r_dcc         <= '0;
            r_dir         <= DIR_NONE;
            r_head        <= '0;
            r_fill        <= '0;
            r_last_rep    <= '0;
            r_last_sample <= '0;
        end else if (r_state == S_UPDATE) begin
            r_pin    <= n_pin;
            r_pulses <= n_pulses;
            r_dcc    <= n_dcc;
            r_dir    <= n_dir;
            r_head   <= n_head;
            r_fill   <= n_fill;
            if (report) begin
                r_last_rep <= r_now;
                if (n_fill != '0) begin
                    r_last_sample <= r_now;
                end
            end
        end
    end

    // ring memory: write on update, registered read
    always_ff @(posedge i_clk) begin
        if ((r_state == S_UPDATE) && mem_we) begin
            r_mem[mem_waddr] <= {r_now, n_pulses};
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // speed datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_rd_addr <= n_rd_addr;
            r_speed   <= '0;
        end
        if (r_state == S_LOAD) begin
            r_prod <= PROD_W'(dp) * PROD_W'(MS_PER_S);
            r_dm   <= dm;
        end
        if ((r_state == S_DIV_WAIT) && div_done) begin
            r_speed <= (div_quo > PROD_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[30:0];
        end
    end

    qwst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // output register: load when free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_out_valid || o_out.ready)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || o_out.ready)) begin
            r_o_time   <= r_last_sample;
            r_o_speed  <= r_speed;
            r_o_dir    <= r_dir;
            r_o_dcc    <= r_dcc;
            r_o_pulses <= r_pulses;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.sample_time         = r_o_time;
    assign o_out.speed               = r_o_speed;
    assign o_out.direction           = r_o_dir;
    assign o_out.count_at_dir_change = r_o_dcc;
    assign o_out.pulse_total         = r_o_pulses;

endmodule

// ===== rtl/core/qwst_checker.sv =====
// ----------------------------------------------------------------------------
// qwst_checker
// Port-level checks on the report channel of the tracker.
// ----------------------------------------------------------------------------
module qwst_checker
    import qwst_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_time,
    input logic [1:0]  i_out_dir,
    input logic [31:0] i_out_dcc
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_time)))
        else $error("report dropped or changed while stalled");

    a_dir_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_dir != DIR_BAD))
        else $error("report carries invalid direction");

    a_none_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_dir == DIR_NONE)) |-> (i_out_dcc == 32'd0))
        else $error("direction change count without a direction");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("report valid right after reset");

endmodule

bind quadrature_wheel_speed_tracker_core qwst_checker u_qwst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_time  (o_out.sample_time),
    .i_out_dir   (o_out.direction),
    .i_out_dcc   (o_out.count_at_dir_change)
);
